// ===== rtl/spiral_walk_cell_generator_defines.svh =====
// ---------------------------------------------------------------------------
// Spiral walk cell generator - assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SPIRAL_WALK_CELL_GENERATOR_DEFINES_SVH
`define SPIRAL_WALK_CELL_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define SWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spiral walk check failed");

// Next-cycle implication.
`define SWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiral walk check failed");

`endif

// ===== rtl/swcg_pkg.sv =====
// ---------------------------------------------------------------------------
// Spiral walk cell generator - package
// Widths, register indexes and small helpers for the spiral walk.
// ---------------------------------------------------------------------------
package swcg_pkg;

  localparam int MAX_GRID = 64;

  localparam int SizeW  = 7;   // grid_size
  localparam int StartW = 6;   // start_row / start_col
  localparam int PosW   = 9;   // signed walk coordinate
  localparam int RunW   = 8;   // run length and leg step
  localparam int CellW  = 13;  // cell number and cell count
  localparam int CountW = 16;  // positions walked
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_START_ROW = 2'd1,
    CFG_START_COL = 2'd2
  } cfg_idx_t;

  typedef logic signed [PosW-1:0] pos_t;

  // Grid side clamped to MAX_GRID.
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] n);
    eff_size = (n > SizeW'(MAX_GRID)) ? SizeW'(MAX_GRID) : n;
  endfunction

  // Coordinate pair lies within an n by n grid.
  function automatic logic on_grid(input pos_t r, input pos_t c,
                                   input logic [SizeW-1:0] n);
    on_grid = !r[PosW-1] && !c[PosW-1] &&
              (r[PosW-2:0] < {1'b0, n}) && (c[PosW-2:0] < {1'b0, n});
  endfunction

endpackage

// ===== rtl/spiral_walk_cell_generator.sv =====
// ---------------------------------------------------------------------------
// Spiral walk cell generator
// Walks a square spiral over an N by N grid from a configured start cell and
// reports, per transaction, the 1-based cell number, grid hit, completion and
// a saturating count of positions walked.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//  in      | in_valid/in_ready    | restart
//  out     | out_valid/out_ready  | cell_number, inside_res, finished,
//          |                      | positions_walked
//
//  Flow: the item is captured in the input register, then moves into the
//  result register once that register is free. One transaction per cycle
//  sustained while out_ready stays high.
//  The walk state advances as an item moves from the input register into
//  the result register, so items are processed strictly in order.
//  Reset: synchronous; walk is marked finished until the first restart.
//  Stalls: out_ready low holds the result; the input register still fills,
//  and in_ready drops only once both stages are occupied.
//
`include "spiral_walk_cell_generator_defines.svh"

module spiral_walk_cell_generator import swcg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [SizeW-1:0]    cfg_data,
  // item input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CellW-1:0]    cell_number,
  output logic                inside_res,
  output logic                finished,
  output logic [CountW-1:0]   positions_walked
);

  // Configuration registers
  logic [SizeW-1:0]  grid_size;
  logic [StartW-1:0] start_row;
  logic [StartW-1:0] start_col;

  // Input register
  logic s1_valid;
  logic s1_restart;

  // Walk state
  pos_t              cur_row, cur_row_next;
  pos_t              cur_col, cur_col_next;
  logic [RunW-1:0]   run_length, run_length_next;
  logic [RunW-1:0]   leg_step, leg_step_next;
  logic              second_leg, second_leg_next;
  logic [CellW-1:0]  cells_seen, cells_seen_next;
  logic [CountW-1:0] walk_count, walk_count_next;
  logic              done_flag, done_flag_next;

  logic              on_cell;
  logic              out_free;
  logic              advance;
  logic [SizeW-1:0]  eff_n;
  logic [CellW-1:0]  total_cells;
  logic [RunW-1:0]   leg_inc;
  logic [CellW-1:0]  row_offset;
  logic [CellW-1:0]  cell_calc;

  assign cfg_ready = 1'b1;

  // Result register free to take the item in the input register.
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  assign eff_n       = eff_size(grid_size);
  assign total_cells = CellW'(eff_n) * CellW'(eff_n);
  assign leg_inc     = leg_step + RunW'(1);

  // Next walk state for the item held in the input register.
  always_comb begin
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    run_length_next = run_length;
    leg_step_next   = leg_step;
    second_leg_next = second_leg;
    cells_seen_next = cells_seen;
    walk_count_next = walk_count;
    done_flag_next  = done_flag;
    on_cell         = 1'b0;
    if (s1_restart) begin
      cur_row_next    = pos_t'({3'b000, start_row});
      cur_col_next    = pos_t'({3'b000, start_col});
      run_length_next = RunW'(1);
      leg_step_next   = '0;
      second_leg_next = 1'b0;
      walk_count_next = CountW'(1);
      on_cell         = on_grid(cur_row_next, cur_col_next, eff_n);
      cells_seen_next = on_cell ? CellW'(1) : '0;
      done_flag_next  = cells_seen_next >= total_cells;
    end else if (!done_flag) begin
      // odd runs go right then down, even runs left then up
      if (!second_leg) begin
        cur_col_next = run_length[0] ? cur_col + 9'sd1 : cur_col - 9'sd1;
      end else begin
        cur_row_next = run_length[0] ? cur_row + 9'sd1 : cur_row - 9'sd1;
      end
      if (leg_inc >= run_length) begin
        leg_step_next = '0;
        if (second_leg) begin
          second_leg_next = 1'b0;
          run_length_next = run_length + RunW'(1);
        end else begin
          second_leg_next = 1'b1;
        end
      end else begin
        leg_step_next = leg_inc;
      end
      if (walk_count != '1) begin
        walk_count_next = walk_count + CountW'(1);
      end
      on_cell = on_grid(cur_row_next, cur_col_next, eff_n);
      if (on_cell) begin
        cells_seen_next = cells_seen + CellW'(1);
      end
      done_flag_next = cells_seen_next >= total_cells;
    end
  end

  // Only valid when on the grid: row and column then fit in six bits.
  assign row_offset = CellW'(cur_row_next[StartW-1:0]) * CellW'(eff_n);
  assign cell_calc  = row_offset + CellW'(cur_col_next[StartW-1:0]) + CellW'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= SizeW'(4);
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size <= cfg_data;
        CFG_START_ROW: start_row <= cfg_data[StartW-1:0];
        CFG_START_COL: start_col <= cfg_data[StartW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_restart <= restart;
    end
  end

  // Walk state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      run_length <= RunW'(1);
      leg_step   <= '0;
      second_leg <= 1'b0;
      cells_seen <= '0;
      walk_count <= '0;
      done_flag  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        cur_row    <= cur_row_next;
        cur_col    <= cur_col_next;
        run_length <= run_length_next;
        leg_step   <= leg_step_next;
        second_leg <= second_leg_next;
        cells_seen <= cells_seen_next;
        walk_count <= walk_count_next;
        done_flag  <= done_flag_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_number      <= on_cell ? cell_calc : '0;
      inside_res       <= on_cell;
      finished         <= done_flag_next;
      positions_walked <= walk_count_next;
    end
  end

  // Assertions
  `SWC_ASSERT_NOW(a_off_grid_zero, out_valid && !inside_res, cell_number == '0)
  `SWC_ASSERT_NOW(a_hit_counted, out_valid && inside_res,
                  cell_number != '0 && positions_walked != '0)
  `SWC_ASSERT_NOW(a_fresh_is_done, walk_count == '0, done_flag)
  `SWC_ASSERT_NEXT(a_idle_advance, advance && done_flag && !s1_restart,
                   out_valid && !inside_res && finished)

endmodule
